/* rtl/nps_pkg.sv */
`timescale 1ns / 1ps
// Shared constants for the next-permutation step unit.
// No dependencies; the interfaces and the top level refer to this package by scoped name.
package nps_pkg;

	localparam int unsigned ELEMENT_COUNT_DEF = 8;
	localparam int unsigned ELEMENT_WIDTH_DEF = 8;

	// Length register: width and reset value.
	localparam int unsigned LEN_W     = 4;
	localparam logic [LEN_W-1:0] LEN_RESET = 4'd8;

endpackage

/* rtl/nps_elem_if.sv */
`timescale 1ns / 1ps
// Request channel: one arrangement of ELEMENT_COUNT elements, element k at bits [k*W +: W].
// Depends on nps_pkg for default sizes.
interface nps_elem_if #(
	parameter int unsigned ELEMENT_COUNT = nps_pkg::ELEMENT_COUNT_DEF,
	parameter int unsigned ELEMENT_WIDTH = nps_pkg::ELEMENT_WIDTH_DEF
);
	logic                                   valid;
	logic                                   ready;
	logic [ELEMENT_COUNT*ELEMENT_WIDTH-1:0] elem;

	modport source (output valid, output elem, input ready);
	modport sink (input valid, input elem, output ready);
endinterface

/* rtl/nps_next_if.sv */
`timescale 1ns / 1ps
// Result channel: next arrangement plus the last-arrangement flag.
// Depends on nps_pkg for default sizes.
interface nps_next_if #(
	parameter int unsigned ELEMENT_COUNT = nps_pkg::ELEMENT_COUNT_DEF,
	parameter int unsigned ELEMENT_WIDTH = nps_pkg::ELEMENT_WIDTH_DEF
);
	logic                                   valid;
	logic                                   ready;
	logic [ELEMENT_COUNT*ELEMENT_WIDTH-1:0] next;
	logic                                   was_last;

	modport source (output valid, output next, output was_last, input ready);
	modport sink (input valid, input next, input was_last, output ready);
endinterface

/* rtl/nps_merge.sv */
`timescale 1ns / 1ps
// Rightmost-set priority merge of the per-lane flags.
// Standalone; used by the step unit for both pivot and swap-partner search.
module nps_merge #(
	parameter int unsigned COUNT = 7,
	parameter int unsigned IW    = 3
) (
	input  logic [COUNT-1:0] flag,
	output logic             any,
	output logic [IW-1:0]    idx
);

	always_comb begin
		idx = '0;
		for (int k = 0; k < COUNT; k++) begin
			if (flag[k]) begin
				idx = IW'(k);
			end
		end
	end

	assign any = |flag;

endmodule

/* rtl/nps_ascent_lane.sv */
`timescale 1ns / 1ps
// One pivot lane: flags position POS when it is smaller than its right neighbor
// and both sit inside the active length. Standalone.
module nps_ascent_lane #(
	parameter int unsigned ELEMENT_WIDTH = 8,
	parameter int unsigned NW            = 4,
	parameter int unsigned POS           = 0
) (
	input  logic [ELEMENT_WIDTH-1:0] cur,
	input  logic [ELEMENT_WIDTH-1:0] right,
	input  logic [NW-1:0]            len,
	output logic                     ascent
);

	assign ascent = (NW'(POS + 1) < len) && (cur < right);

endmodule

/* rtl/nps_larger_lane.sv */
`timescale 1ns / 1ps
// One swap-partner lane: flags position POS when it lies right of the pivot,
// inside the active length, and holds a value above the pivot value. Standalone.
module nps_larger_lane #(
	parameter int unsigned ELEMENT_WIDTH = 8,
	parameter int unsigned IW            = 3,
	parameter int unsigned NW            = 4,
	parameter int unsigned POS           = 0
) (
	input  logic [ELEMENT_WIDTH-1:0] val,
	input  logic [ELEMENT_WIDTH-1:0] piv_val,
	input  logic [IW-1:0]            piv,
	input  logic                     found,
	input  logic [NW-1:0]            len,
	output logic                     larger
);

	assign larger = found && (IW'(POS) > piv) && (NW'(POS) < len) && (val > piv_val);

endmodule

/* rtl/nps_place_lane.sv */
`timescale 1ns / 1ps
// One output lane: picks the element that lands at position POS after the
// swap and the suffix reversal. Standalone.
module nps_place_lane #(
	parameter int unsigned ELEMENT_COUNT = 8,
	parameter int unsigned ELEMENT_WIDTH = 8,
	parameter int unsigned IW            = 3,
	parameter int unsigned NW            = 4,
	parameter int unsigned POS           = 0
) (
	input  logic [ELEMENT_COUNT-1:0][ELEMENT_WIDTH-1:0] elem,
	input  logic                                        found,
	input  logic [IW-1:0]                               piv,
	input  logic [IW-1:0]                               pick,
	input  logic [NW-1:0]                               len,
	output logic [ELEMENT_WIDTH-1:0]                    out
);

	logic [NW:0]   mirror;
	logic [IW-1:0] src;

	// Reversed suffix: position k takes the element from len + piv - k.
	assign mirror = (NW+1)'(len) + (NW+1)'(piv) - (NW+1)'(POS);
	assign src    = mirror[IW-1:0];

	always_comb begin
		if (!found || (IW'(POS) < piv) || (NW'(POS) >= len)) begin
			out = elem[POS];
		end else if (IW'(POS) == piv) begin
			out = elem[pick];
		end else if (src == pick) begin
			// the partner slot holds the old pivot after the swap
			out = elem[piv];
		end else begin
			out = elem[src];
		end
	end

endmodule

/* rtl/next_permutation_step_unit.sv */
`timescale 1ns / 1ps
// Top level of the next-permutation step unit: length register, three-stage lane pipeline.
// Depends on nps_pkg, nps_elem_if, nps_next_if, nps_merge and the three lane modules.
//
// Channel   | Dir | Handshake      | Payload
// ----------+-----+----------------+---------------------------------------------
// elems     | in  | valid / ready  | elem: ELEMENT_COUNT x ELEMENT_WIDTH arrangement
// result    | out | valid / ready  | next: next arrangement, was_last: no pivot
// length    | in  | we, no ready   | wdata: 4-bit active length (reset 8)
//
// Throughput: one request per cycle while result is not stalled; an accepted request passes
// through the stage 1, stage 2 and stage 3 registers before it shows as a valid result.
// Stage 1 finds the pivot, stage 2 the swap partner, stage 3 the rearranged output register.
// Reset clears all stage valids and sets the active length to eight.
// Stalls on result back up through every stage; a stage advances whenever the next is free.
module next_permutation_step_unit #(
	parameter int unsigned ELEMENT_COUNT = nps_pkg::ELEMENT_COUNT_DEF,
	parameter int unsigned ELEMENT_WIDTH = nps_pkg::ELEMENT_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	nps_elem_if.sink                     elems,
	nps_next_if.source                   result,
	input  logic                         length_we,
	input  logic [nps_pkg::LEN_W-1:0]    length_wdata
);

	localparam int unsigned N  = ELEMENT_COUNT;
	localparam int unsigned W  = ELEMENT_WIDTH;
	localparam int unsigned IW = $clog2(N);
	localparam int unsigned NW = $clog2(N + 1);
	localparam int unsigned LW = nps_pkg::LEN_W;

	// ------------------------------------------------------------------
	// Length register, saturated to the element count
	// ------------------------------------------------------------------
	logic [LW-1:0] len_q;
	logic [NW-1:0] len_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= nps_pkg::LEN_RESET;
		end else if (length_we) begin
			len_q <= length_wdata;
		end
	end

	assign len_eff = (len_q > LW'(N)) ? NW'(N) : NW'(len_q);

	// ------------------------------------------------------------------
	// Stage enables: advance a stage when the one after it is empty or drains
	// ------------------------------------------------------------------
	logic vld_s1, vld_s2, vld_s3;
	logic en1, en2, en3;

	assign en3         = !vld_s3 || result.ready;
	assign en2         = !vld_s2 || en3;
	assign en1         = !vld_s1 || en2;
	assign elems.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (en1) begin
				vld_s1 <= elems.valid;
			end
			if (en2) begin
				vld_s2 <= vld_s1;
			end
			if (en3) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 1: ascent lanes, merged to the rightmost pivot
	// ------------------------------------------------------------------
	logic [N-1:0][W-1:0] elem_in;
	logic [N-2:0]        ascent;
	logic                piv_any;
	logic [IW-1:0]       piv_idx;

	for (genvar k = 0; k < N; k++) begin : g_unpack
		assign elem_in[k] = elems.elem[k*W +: W];
	end

	for (genvar k = 0; k < N - 1; k++) begin : g_ascent
		nps_ascent_lane #(
			.ELEMENT_WIDTH(W),
			.NW           (NW),
			.POS          (k)
		) u_lane (
			.cur   (elem_in[k]),
			.right (elem_in[k+1]),
			.len   (len_eff),
			.ascent(ascent[k])
		);
	end

	nps_merge #(
		.COUNT(N - 1),
		.IW   (IW)
	) u_piv_merge (
		.flag(ascent),
		.any (piv_any),
		.idx (piv_idx)
	);

	logic [N-1:0][W-1:0] elem_s1;
	logic                found_s1;
	logic [IW-1:0]       piv_s1;

	always_ff @(posedge clk) begin
		if (en1 && elems.valid) begin
			elem_s1  <= elem_in;
			found_s1 <= piv_any;
			piv_s1   <= piv_idx;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: larger-than-pivot lanes, merged to the rightmost partner
	// ------------------------------------------------------------------
	logic [W-1:0]  piv_val;
	logic [N-1:0]  larger;
	logic          pick_any;
	logic [IW-1:0] pick_idx;

	assign piv_val = elem_s1[piv_s1];

	for (genvar k = 0; k < N; k++) begin : g_larger
		nps_larger_lane #(
			.ELEMENT_WIDTH(W),
			.IW           (IW),
			.NW           (NW),
			.POS          (k)
		) u_lane (
			.val    (elem_s1[k]),
			.piv_val(piv_val),
			.piv    (piv_s1),
			.found  (found_s1),
			.len    (len_eff),
			.larger (larger[k])
		);
	end

	nps_merge #(
		.COUNT(N),
		.IW   (IW)
	) u_pick_merge (
		.flag(larger),
		.any (pick_any),
		.idx (pick_idx)
	);

	logic [N-1:0][W-1:0] elem_s2;
	logic                found_s2;
	logic [IW-1:0]       piv_s2;
	logic [IW-1:0]       pick_s2;

	always_ff @(posedge clk) begin
		if (en2 && vld_s1) begin
			elem_s2  <= elem_s1;
			found_s2 <= found_s1;
			piv_s2   <= piv_s1;
			pick_s2  <= pick_idx;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: place lanes build the swapped, reversed arrangement
	// ------------------------------------------------------------------
	logic [N-1:0][W-1:0] placed;

	for (genvar k = 0; k < N; k++) begin : g_place
		nps_place_lane #(
			.ELEMENT_COUNT(N),
			.ELEMENT_WIDTH(W),
			.IW           (IW),
			.NW           (NW),
			.POS          (k)
		) u_lane (
			.elem (elem_s2),
			.found(found_s2),
			.piv  (piv_s2),
			.pick (pick_s2),
			.len  (len_eff),
			.out  (placed[k])
		);
	end

	logic [N-1:0][W-1:0] next_s3;
	logic                last_s3;

	// Hold the result while the sink stalls; refill as it drains.
	always_ff @(posedge clk) begin
		if (en3 && vld_s2) begin
			next_s3 <= placed;
			last_s3 <= !found_s2;
		end
	end

	assign result.valid    = vld_s3;
	assign result.next     = next_s3;
	assign result.was_last = last_s3;

`ifndef ASSERT_OFF
	// An accepted request always lands in stage 1 on the next edge.
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(elems.valid && elems.ready) |=> vld_s1)
		else $error("accepted request did not enter stage 1");

	// A pivot always has a neighbor to its right inside the active length.
	a_pivot_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && found_s1) |-> ((NW+1)'(piv_s1) + (NW+1)'(2) <= (NW+1)'(len_eff)))
		else $error("pivot lies outside the active length");

	// With a pivot, the right neighbor is larger, so a partner must exist.
	a_partner_exists: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && found_s1) |-> pick_any)
		else $error("pivot found but no swap partner");

	// The partner always sits right of the pivot.
	a_partner_right: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && found_s1) |-> (pick_idx > piv_s1))
		else $error("swap partner not right of pivot");
`endif

endmodule
